FILE: sv/assert_macros.svh
// Assertion macros shared by the deframer RTL.
// Each macro expects a signal named clock and a synchronous reset named reset in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define WSD_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define WSD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/wsd_pkg.sv
// Shared types, codes and constants for the WebSocket frame deframer.
// No dependencies; every other RTL file but assert_macros.svh refers to this package by scoped names.
`timescale 1ns / 1ps

package wsd_pkg;

   typedef logic [7:0]  byte_type;
   typedef logic [15:0] len_type;
   typedef logic [3:0]  opcode_type;

   // Parser phases, one-hot coded.
   typedef enum logic [5:0] {
      PH_OPCODE  = 6'b000001,
      PH_LEN     = 6'b000010,
      PH_EXT16   = 6'b000100,
      PH_EXT64   = 6'b001000,
      PH_MASK    = 6'b010000,
      PH_PAYLOAD = 6'b100000
   } wsd_phase_type;

   // Error codes reported on the result channel.
   typedef enum logic [2:0] {
      ERR_NONE       = 3'd0,
      ERR_BAD_OPCODE = 3'd1,
      ERR_FRAG_CTRL  = 3'd2,
      ERR_CTRL_LONG  = 3'd3,
      ERR_OVER_64K   = 3'd4,
      ERR_OVER_MAX   = 3'd5,
      ERR_IN_ERROR   = 3'd6
   } wsd_err_type;

   // Frame opcodes.
   localparam opcode_type OPC_CONT   = 4'h0;
   localparam opcode_type OPC_TEXT   = 4'h1;
   localparam opcode_type OPC_BINARY = 4'h2;
   localparam opcode_type OPC_CLOSE  = 4'h8;
   localparam opcode_type OPC_PING   = 4'h9;
   localparam opcode_type OPC_PONG   = 4'hA;

   // Length field codes and limits.
   localparam logic [6:0] LEN_EXT16_CODE  = 7'd126;
   localparam len_type    CTRL_MAX_LEN    = 16'd125;
   localparam len_type    MAX_LEN_RESET   = 16'hFFFF;
   localparam logic [3:0] EXT16_BYTES     = 4'd2;
   localparam logic [3:0] EXT64_BYTES     = 4'd8;
   localparam logic [3:0] EXT64_LOW_BYTES = 4'd4;

   // One result word.
   typedef struct packed {
      logic        data_valid;
      byte_type    data_byte;
      len_type     payload_offset;
      opcode_type  frame_opcode;
      logic        frame_fin;
      logic        frame_done;
      logic        close_seen;
      wsd_err_type error_code;
   } wsd_result_type;

   // Parser status seen by the top level.
   typedef struct packed {
      logic          in_error;
      wsd_phase_type phase;
   } wsd_status_type;

   // True for the opcodes the protocol defines.
   function automatic logic opcode_known(input opcode_type op);
      logic known;
      case (op) inside
         OPC_CONT, OPC_TEXT, OPC_BINARY, OPC_CLOSE, OPC_PING, OPC_PONG: known = 1'b1;
         default: known = 1'b0;
      endcase
      return known;
   endfunction

endpackage

FILE: sv/wsd_if.sv
// Valid/ready channel interfaces for the deframer: received bytes in, result words out.
// Depends on wsd_pkg for payload types.
`timescale 1ns / 1ps

interface wsd_req_if;
   logic               valid;
   logic               ready;
   wsd_pkg::byte_type  in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

interface wsd_rsp_if;
   logic                 valid;
   logic                 ready;
   logic                 data_valid;
   wsd_pkg::byte_type    data_byte;
   wsd_pkg::len_type     payload_offset;
   wsd_pkg::opcode_type  frame_opcode;
   logic                 frame_fin;
   logic                 frame_done;
   logic                 close_seen;
   logic [2:0]           error_code;

   modport source (output valid, output data_valid, output data_byte, output payload_offset,
                   output frame_opcode, output frame_fin, output frame_done,
                   output close_seen, output error_code, input ready);
   modport sink   (input valid, input data_valid, input data_byte, input payload_offset,
                   input frame_opcode, input frame_fin, input frame_done,
                   input close_seen, input error_code, output ready);
endinterface

FILE: sv/wsd_in_reg.sv
// Input register stage: captures one received byte per word from the request channel.
// Depends on wsd_pkg and wsd_req_if.
`timescale 1ns / 1ps

module wsd_in_reg (
   input  logic              clock,
   input  logic              reset,
   wsd_req_if.sink           req_ch,
   input  logic              load_ok,
   output logic              byte_valid,
   output wsd_pkg::byte_type byte_out
);

   logic              valid_ff;
   logic              valid_in;
   wsd_pkg::byte_type byte_ff;

   // The stage can take a word when empty or when its word moves on this cycle.
   assign req_ch.ready = !valid_ff || load_ok;
   assign valid_in     = req_ch.ready ? req_ch.valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         byte_ff <= req_ch.in_byte;
      end
   end

   assign byte_valid = valid_ff;
   assign byte_out   = byte_ff;

endmodule

FILE: sv/wsd_parser.sv
// Frame parser: holds the per-frame state and computes one result word per byte.
// Depends on wsd_pkg.
`timescale 1ns / 1ps

module wsd_parser (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  wsd_pkg::byte_type       in_byte,
   input  wsd_pkg::len_type        max_payload_len,
   output wsd_pkg::wsd_result_type result,
   output wsd_pkg::wsd_status_type status
);

   wsd_pkg::wsd_phase_type phase_ff, phase_in;
   logic [3:0]             len_left_ff, len_left_in;
   logic [31:0]            len_accum_ff, len_accum_in;
   wsd_pkg::len_type       pay_total_ff, pay_total_in;
   wsd_pkg::len_type       pay_count_ff, pay_count_in;
   logic [3:0][7:0]        mask_key_ff, mask_key_in;
   logic [1:0]             mask_seen_ff, mask_seen_in;
   wsd_pkg::opcode_type    cur_opcode_ff, cur_opcode_in;
   logic                   cur_fin_ff, cur_fin_in;
   logic                   cur_masked_ff, cur_masked_in;
   logic                   error_ff, error_in;

   logic                   len_final;
   wsd_pkg::len_type       len_val;
   wsd_pkg::wsd_err_type   err;
   logic                   done;
   logic                   dvalid;
   wsd_pkg::byte_type      dbyte;
   wsd_pkg::byte_type      key;
   wsd_pkg::len_type       offs;
   wsd_pkg::len_type       count_next;

   // Next state and result for the byte at the input register.
   always_comb begin
      phase_in      = phase_ff;
      len_left_in   = len_left_ff;
      len_accum_in  = len_accum_ff;
      pay_total_in  = pay_total_ff;
      pay_count_in  = pay_count_ff;
      mask_key_in   = mask_key_ff;
      mask_seen_in  = mask_seen_ff;
      cur_opcode_in = cur_opcode_ff;
      cur_fin_in    = cur_fin_ff;
      cur_masked_in = cur_masked_ff;
      error_in      = error_ff;
      len_final     = 1'b0;
      len_val       = '0;
      err           = wsd_pkg::ERR_NONE;
      done          = 1'b0;
      dvalid        = 1'b0;
      dbyte         = '0;
      key           = '0;
      offs          = '0;
      count_next    = pay_count_ff + 16'd1;

      if (!error_ff) begin
         unique case (phase_ff)
            wsd_pkg::PH_OPCODE: begin
               cur_fin_in    = in_byte[7];
               cur_opcode_in = in_byte[3:0];
               if (!wsd_pkg::opcode_known(in_byte[3:0])) begin
                  err = wsd_pkg::ERR_BAD_OPCODE;
               end else if (in_byte[3] && !in_byte[7]) begin
                  err = wsd_pkg::ERR_FRAG_CTRL;
               end else begin
                  phase_in = wsd_pkg::PH_LEN;
               end
            end
            wsd_pkg::PH_LEN: begin
               cur_masked_in = in_byte[7];
               if (in_byte[6:0] < wsd_pkg::LEN_EXT16_CODE) begin
                  len_final = 1'b1;
                  len_val   = {9'd0, in_byte[6:0]};
               end else begin
                  len_accum_in = '0;
                  if (in_byte[6:0] == wsd_pkg::LEN_EXT16_CODE) begin
                     len_left_in = wsd_pkg::EXT16_BYTES;
                     phase_in    = wsd_pkg::PH_EXT16;
                  end else begin
                     len_left_in = wsd_pkg::EXT64_BYTES;
                     phase_in    = wsd_pkg::PH_EXT64;
                  end
               end
            end
            wsd_pkg::PH_EXT16: begin
               len_accum_in = {16'd0, len_accum_ff[7:0], in_byte};
               len_left_in  = len_left_ff - 4'd1;
               len_final    = (len_left_ff == 4'd1);
               len_val      = len_accum_in[15:0];
            end
            wsd_pkg::PH_EXT64: begin
               // The upper four length bytes must all be zero.
               if (len_left_ff > wsd_pkg::EXT64_LOW_BYTES && in_byte != 8'd0) begin
                  err = wsd_pkg::ERR_OVER_64K;
               end else begin
                  if (len_left_ff <= wsd_pkg::EXT64_LOW_BYTES) begin
                     len_accum_in = {len_accum_ff[23:0], in_byte};
                  end
                  len_left_in = len_left_ff - 4'd1;
                  len_val     = len_accum_in[15:0];
                  if (len_left_ff == 4'd1) begin
                     if (len_accum_in[31:16] != 16'd0) begin
                        err = wsd_pkg::ERR_OVER_64K;
                     end else begin
                        len_final = 1'b1;
                     end
                  end
               end
            end
            wsd_pkg::PH_MASK: begin
               mask_key_in[mask_seen_ff] = in_byte;
               mask_seen_in              = mask_seen_ff + 2'd1;
               if (mask_seen_ff == 2'd3) begin
                  pay_count_in = '0;
                  if (pay_total_ff == 16'd0) begin
                     done     = 1'b1;
                     phase_in = wsd_pkg::PH_OPCODE;
                  end else begin
                     phase_in = wsd_pkg::PH_PAYLOAD;
                  end
               end
            end
            wsd_pkg::PH_PAYLOAD: begin
               if (cur_masked_ff) begin
                  key = mask_key_ff[pay_count_ff[1:0]];
               end
               dvalid       = 1'b1;
               dbyte        = in_byte ^ key;
               offs         = pay_count_ff;
               pay_count_in = count_next;
               if (count_next >= pay_total_ff) begin
                  done     = 1'b1;
                  phase_in = wsd_pkg::PH_OPCODE;
               end
            end
            default: begin
               phase_in = wsd_pkg::PH_OPCODE;
            end
         endcase

         // The length is known: check it against the limits and choose the next phase.
         if (len_final) begin
            if (cur_opcode_ff[3] && len_val > wsd_pkg::CTRL_MAX_LEN) begin
               err = wsd_pkg::ERR_CTRL_LONG;
            end else if (!cur_opcode_ff[3] && len_val > max_payload_len) begin
               err = wsd_pkg::ERR_OVER_MAX;
            end else begin
               pay_total_in = len_val;
               pay_count_in = '0;
               if (cur_masked_in) begin
                  mask_seen_in = '0;
                  phase_in     = wsd_pkg::PH_MASK;
               end else if (len_val == 16'd0) begin
                  done     = 1'b1;
                  phase_in = wsd_pkg::PH_OPCODE;
               end else begin
                  phase_in = wsd_pkg::PH_PAYLOAD;
               end
            end
         end

         // An error suppresses data and completion and latches until reset.
         if (err != wsd_pkg::ERR_NONE) begin
            error_in = 1'b1;
            dvalid   = 1'b0;
            done     = 1'b0;
            dbyte    = '0;
            offs     = '0;
         end
      end
   end

   // Result word; once in error every byte answers with the in-error code only.
   always_comb begin
      result = '0;
      if (error_ff) begin
         result.error_code = wsd_pkg::ERR_IN_ERROR;
      end else begin
         result.data_valid     = dvalid;
         result.data_byte      = dbyte;
         result.payload_offset = offs;
         result.frame_opcode   = cur_opcode_in;
         result.frame_fin      = cur_fin_in;
         result.frame_done     = done;
         result.close_seen     = done && (cur_opcode_in == wsd_pkg::OPC_CLOSE);
         result.error_code     = err;
      end
   end

   // State advances once for each byte handed to the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= wsd_pkg::PH_OPCODE;
         len_left_ff   <= '0;
         len_accum_ff  <= '0;
         pay_total_ff  <= '0;
         pay_count_ff  <= '0;
         mask_key_ff   <= '0;
         mask_seen_ff  <= '0;
         cur_opcode_ff <= '0;
         cur_fin_ff    <= 1'b0;
         cur_masked_ff <= 1'b0;
         error_ff      <= 1'b0;
      end else if (step) begin
         phase_ff      <= phase_in;
         len_left_ff   <= len_left_in;
         len_accum_ff  <= len_accum_in;
         pay_total_ff  <= pay_total_in;
         pay_count_ff  <= pay_count_in;
         mask_key_ff   <= mask_key_in;
         mask_seen_ff  <= mask_seen_in;
         cur_opcode_ff <= cur_opcode_in;
         cur_fin_ff    <= cur_fin_in;
         cur_masked_ff <= cur_masked_in;
         error_ff      <= error_in;
      end
   end

   assign status.in_error = error_ff;
   assign status.phase    = phase_ff;

endmodule

FILE: sv/wsd_out_reg.sv
// Result register stage: holds one result word until the response channel takes it.
// Depends on wsd_pkg and wsd_rsp_if.
`timescale 1ns / 1ps

module wsd_out_reg (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  wsd_pkg::wsd_result_type result,
   output logic                    load_ok,
   wsd_rsp_if.source               rsp_ch
);

   logic                    valid_ff;
   logic                    valid_in;
   wsd_pkg::wsd_result_type result_ff;

   // The register loads when empty or when its word is taken this cycle.
   assign load_ok  = !valid_ff || rsp_ch.ready;
   assign valid_in = load_ok ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_ok && in_valid) begin
         result_ff <= result;
      end
   end

   assign rsp_ch.valid          = valid_ff;
   assign rsp_ch.data_valid     = result_ff.data_valid;
   assign rsp_ch.data_byte      = result_ff.data_byte;
   assign rsp_ch.payload_offset = result_ff.payload_offset;
   assign rsp_ch.frame_opcode   = result_ff.frame_opcode;
   assign rsp_ch.frame_fin      = result_ff.frame_fin;
   assign rsp_ch.frame_done     = result_ff.frame_done;
   assign rsp_ch.close_seen     = result_ff.close_seen;
   assign rsp_ch.error_code     = result_ff.error_code;

endmodule

FILE: sv/websocket_frame_deframer_core.sv
// Path: a byte accepted from the request channel waits in the input register, is parsed as it
// moves into the result register, and is offered on the response channel from there until taken.
// Throughput: one byte per cycle; the parser state loops through one register set
// and its next value depends on a single byte, so nothing limits the rate but backpressure.
// Reset is synchronous and active high: parser state clears to the opcode phase,
// any latched error is cleared and max_payload_len returns to 65535.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module websocket_frame_deframer_core (
   input  logic             clock,
   input  logic             reset,
   wsd_req_if.sink          req_ch,
   wsd_rsp_if.source        rsp_ch,
   input  logic             csr_wr_en,
   input  wsd_pkg::len_type csr_wr_data
);

   wsd_pkg::len_type        max_len_ff;
   wsd_pkg::len_type        max_len_in;
   logic                    load_ok;
   logic                    byte_valid;
   wsd_pkg::byte_type       byte_word;
   logic                    step;
   wsd_pkg::wsd_result_type result;
   wsd_pkg::wsd_status_type status;

   // Maximum data payload register.
   assign max_len_in = csr_wr_en ? csr_wr_data : max_len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= wsd_pkg::MAX_LEN_RESET;
      end else begin
         max_len_ff <= max_len_in;
      end
   end

   // A byte is parsed in the cycle it moves from the input register to the result register.
   assign step = byte_valid && load_ok;

   wsd_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .load_ok    (load_ok),
      .byte_valid (byte_valid),
      .byte_out   (byte_word)
   );

   wsd_parser u_parser (
      .clock           (clock),
      .reset           (reset),
      .step            (step),
      .in_byte         (byte_word),
      .max_payload_len (max_len_ff),
      .result          (result),
      .status          (status)
   );

   wsd_out_reg u_out_reg (
      .clock    (clock),
      .reset    (reset),
      .in_valid (byte_valid),
      .result   (result),
      .load_ok  (load_ok),
      .rsp_ch   (rsp_ch)
   );

   // Checks on the parser and the result path.
   `WSD_ASSERT_NEXT(a_error_sticks, status.in_error, status.in_error, "error flag dropped")
   `WSD_ASSERT_NEXT(a_error_answer, status.in_error && step, rsp_ch.valid && (rsp_ch.error_code == wsd_pkg::ERR_IN_ERROR), "in-error word missing")
   `WSD_ASSERT_IMPL(a_close_done, rsp_ch.valid && rsp_ch.close_seen, rsp_ch.frame_done, "close without frame end")
   `WSD_ASSERT_IMPL(a_data_no_err, rsp_ch.valid && rsp_ch.data_valid, rsp_ch.error_code == wsd_pkg::ERR_NONE, "data word with error")

endmodule
